// ===== rtl/core/lstw_pkg.sv =====
// Shared types, constants and the arctangent table of the lidar point transform.
package lstw_pkg;

  // Scan size and number of CORDIC rotations
  localparam int MAX_BEAMS     = 1024;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int ROT_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // Beam index limit, wide enough for scan sizes below 2^17
  localparam logic [16:0] MaxBeamsW = 17'(MAX_BEAMS);

  // CORDIC datapath widths: x/y with 20 fraction bits, z with 24 fraction bits
  localparam int XW = 27;
  localparam int ZW = 28;
  localparam int RW = XW - 8;

  // Angle constants in Q3.13
  localparam logic signed [17:0] Q13_PI      = 18'sd25736;
  localparam logic signed [17:0] Q13_TWO_PI  = 18'sd51472;
  localparam logic signed [17:0] Q13_HALF_PI = 18'sd12868;

  // Inverse CORDIC gain in Q0.16
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  // Saturation limits of a Q12.12 position
  localparam logic signed [23:0] W24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] W24_MIN = 24'sh800000;

  // Configuration register indexes
  localparam logic [1:0] REG_START_ANGLE = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] REG_WINDOW      = 2'd2;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic signed [15:0] start_angle;
    logic [12:0]        angle_step;
    logic [14:0]        window_half_width;
  } lstw_cfg_t;

  // Fields that ride along with an item through the pipeline
  typedef struct packed {
    logic [9:0]         beam;
    logic               bad;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
  } lstw_side_t;

  // CORDIC working set of one item
  typedef struct packed {
    lstw_side_t           side;
    logic                 flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } lstw_rot_t;

  // Result item
  typedef struct packed {
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic [9:0]         point_beam;
    logic               point_invalid;
  } lstw_point_t;

  // Arctangent of 2^-i, 24 fraction bits, rounded
  function automatic logic [23:0] atan_q24(input int i);
    logic [23:0] v;
    case (i)
      0:       v = 24'd13176795;
      1:       v = 24'd7778716;
      2:       v = 24'd4110060;
      3:       v = 24'd2086331;
      4:       v = 24'd1047214;
      5:       v = 24'd524117;
      6:       v = 24'd262123;
      7:       v = 24'd131069;
      8:       v = 24'd65536;
      9:       v = 24'd32768;
      10:      v = 24'd16384;
      11:      v = 24'd8192;
      12:      v = 24'd4096;
      13:      v = 24'd2048;
      14:      v = 24'd1024;
      15:      v = 24'd512;
      16:      v = 24'd256;
      17:      v = 24'd128;
      18:      v = 24'd64;
      19:      v = 24'd32;
      20:      v = 24'd16;
      21:      v = 24'd8;
      22:      v = 24'd4;
      23:      v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/lstw_angle.sv =====
// Front stages: beam angle, window test, angle wrap and quadrant fold.
module lstw_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  lstw_pkg::lstw_side_t in_side,
  input  logic [15:0]        in_range,
  input  logic signed [15:0] in_heading,
  input  lstw_pkg::lstw_cfg_t  cfg,
  output logic               out_valid,
  output lstw_pkg::lstw_rot_t  out_rot
);
  import lstw_pkg::*;

  // Stage A: products
  logic [31:0]        range_prod;
  logic [22:0]        step_prod;
  logic               in_span;
  logic               a_valid;
  lstw_side_t         a_side;
  logic [22:0]        a_prod;
  logic [23:0]        a_x0;
  logic signed [15:0] a_heading;

  // Stage B: angle sum and window
  logic signed [24:0] beam_angle;
  logic signed [24:0] win_ext;
  logic signed [24:0] angle_sum;
  logic               in_win;
  logic               b_valid;
  lstw_side_t         b_side;
  logic [23:0]        b_x0;
  logic signed [17:0] b_t;

  // Stage C: wrap
  logic signed [17:0] t_wrap;
  logic               c_valid;
  lstw_side_t         c_side;
  logic [23:0]        c_x0;
  logic signed [15:0] c_t;

  // Stage D: fold
  logic signed [17:0] c_t_ext;
  logic signed [17:0] t_fold;
  logic               fold;

  // Form the beam products and the start magnitude
  assign range_prod = 32'(in_range) * 32'(INV_GAIN_Q16);
  assign step_prod  = 23'(in_side.beam) * 23'(cfg.angle_step);
  assign in_span    = {7'd0, in_side.beam} < MaxBeamsW;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid && in_span;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side    <= in_side;
      a_prod    <= step_prod;
      a_x0      <= range_prod[31:8];
      a_heading <= in_heading;
    end
  end

  // Add the start angle, test the window, add the heading
  assign beam_angle = $signed({{9{cfg.start_angle[15]}}, cfg.start_angle})
                    + $signed({2'b00, a_prod});
  assign win_ext    = $signed({10'd0, cfg.window_half_width});
  assign in_win     = (beam_angle >= -win_ext) && (beam_angle <= win_ext);
  assign angle_sum  = beam_angle + $signed({{9{a_heading[15]}}, a_heading});

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      // drop valid beams outside the window; invalid beams always pass
      b_valid <= a_valid && (a_side.bad || in_win);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= a_side;
      b_x0   <= a_x0;
      b_t    <= angle_sum[17:0];
    end
  end

  // Wrap the sum into plus or minus pi
  always_comb begin
    if (b_t > Q13_PI) begin
      t_wrap = b_t - Q13_TWO_PI;
    end else if (b_t < -Q13_PI) begin
      t_wrap = b_t + Q13_TWO_PI;
    end else begin
      t_wrap = b_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= b_side;
      c_x0   <= b_x0;
      c_t    <= t_wrap[15:0];
    end
  end

  // Fold into the right half plane; the result is negated at the end
  assign c_t_ext = $signed({{2{c_t[15]}}, c_t});

  always_comb begin
    if (c_t_ext > Q13_HALF_PI) begin
      t_fold = c_t_ext - Q13_PI;
      fold   = 1'b1;
    end else if (c_t_ext < -Q13_HALF_PI) begin
      t_fold = c_t_ext + Q13_PI;
      fold   = 1'b1;
    end else begin
      t_fold = c_t_ext;
      fold   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot.side <= c_side;
      out_rot.flip <= fold;
      out_rot.x    <= $signed({{(XW-24){1'b0}}, c_x0});
      out_rot.y    <= '0;
      out_rot.z    <= $signed({{(ZW-26){t_fold[14]}}, t_fold[14:0], 11'd0});
    end
  end

endmodule

// ===== rtl/core/lstw_cordic.sv =====
// Pipelined CORDIC rotator, one rotation per register stage.
module lstw_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  lstw_pkg::lstw_rot_t in_rot,
  output logic              out_valid,
  output lstw_pkg::lstw_rot_t out_rot
);
  import lstw_pkg::*;

  logic      vld [ROT_STAGES+1];
  lstw_rot_t st  [ROT_STAGES+1];

  assign vld[0] = in_valid;
  assign st[0]  = in_rot;

  for (genvar i = 0; i < ROT_STAGES; i++) begin : g_rot
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] ang;
    lstw_rot_t            nxt;

    // Rotate toward z = 0 by the arctangent of 2^-i
    always_comb begin
      dx  = st[i].y >>> i;
      dy  = st[i].x >>> i;
      ang = $signed({{(ZW-24){1'b0}}, atan_q24(i)});
      nxt = st[i];
      if (!st[i].z[ZW-1]) begin
        nxt.x = st[i].x - dx;
        nxt.y = st[i].y + dy;
        nxt.z = st[i].z - ang;
      end else begin
        nxt.x = st[i].x + dx;
        nxt.y = st[i].y - dy;
        nxt.z = st[i].z + ang;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[ROT_STAGES];
  assign out_rot   = st[ROT_STAGES];

endmodule

// ===== rtl/core/lstw_point.sv =====
// Back stages: undo the fold, round to Q12.12, add the pose and saturate.
module lstw_point (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  lstw_pkg::lstw_rot_t   in_rot,
  output logic                out_valid,
  output lstw_pkg::lstw_point_t out_point
);
  import lstw_pkg::*;

  logic signed [XW-1:0] xn;
  logic signed [XW-1:0] yn;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;
  logic                 e_valid;
  lstw_side_t           e_side;
  logic signed [RW-1:0] e_rx;
  logic signed [RW-1:0] e_ry;
  logic signed [24:0]   sum_x;
  logic signed [24:0]   sum_y;
  logic signed [23:0]   sat_x;
  logic signed [23:0]   sat_y;

  // Negate folded vectors and round away 8 fraction bits
  assign xn = in_rot.flip ? -in_rot.x : in_rot.x;
  assign yn = in_rot.flip ? -in_rot.y : in_rot.y;
  assign xr = xn + XW'(128);
  assign yr = yn + XW'(128);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side <= in_rot.side;
      e_rx   <= xr[XW-1:8];
      e_ry   <= yr[XW-1:8];
    end
  end

  // Add the pose and clamp to the 24-bit range
  assign sum_x = $signed({e_side.pose_x[23], e_side.pose_x})
               + $signed({{(25-RW){e_rx[RW-1]}}, e_rx});
  assign sum_y = $signed({e_side.pose_y[23], e_side.pose_y})
               + $signed({{(25-RW){e_ry[RW-1]}}, e_ry});

  always_comb begin
    if (sum_x[24] != sum_x[23]) begin
      sat_x = sum_x[24] ? W24_MIN : W24_MAX;
    end else begin
      sat_x = sum_x[23:0];
    end
    if (sum_y[24] != sum_y[23]) begin
      sat_y = sum_y[24] ? W24_MIN : W24_MAX;
    end else begin
      sat_y = sum_y[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= e_valid;
    end
  end

  // Invalid ranges report the pose itself
  always_ff @(posedge clk) begin
    if (en) begin
      out_point.world_x       <= e_side.bad ? e_side.pose_x : sat_x;
      out_point.world_y       <= e_side.bad ? e_side.pose_y : sat_y;
      out_point.point_beam    <= e_side.beam;
      out_point.point_invalid <= e_side.bad;
    end
  end

endmodule

// ===== rtl/core/lstw_skid.sv =====
// Two-entry output queue that decouples the pipeline from the receiver.
module lstw_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lstw_pkg::lstw_point_t push_point,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output lstw_pkg::lstw_point_t out_point
);
  import lstw_pkg::*;

  lstw_point_t q0;
  lstw_point_t q1;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        pop;

  assign room      = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_point = q0;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Shift the queue on a pop, fill the first free entry on a push
  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      q0 <= push_point;
    end else if (pop) begin
      q0 <= q1;
    end
    if (push && count != 2'd0 && !(count == 2'd1 && pop)) begin
      q1 <= push_point;
    end
  end

endmodule

// ===== rtl/core/lidar_scan_to_world_points.sv =====
// Top level of the lidar beam to world point transform.
// Usage:
//   Configure start_angle (0x0), angle_step (0x4) and window_half_width (0x8)
//   over the APB port while no request is in flight; pready is always high.
//   Each request on s_axis carries one beam and the robot pose. A beam whose
//   index is at or beyond the scan size, or a valid beam outside the angle
//   window, yields no result; every other request yields one point on m_axis.
//   Invalid ranges yield the pose position with point_invalid set.
// Timing:
//   One request is taken per cycle when the output side keeps up. A result
//   passes four angle stages, one stage per CORDIC rotation, two rounding
//   and pose stages and a two-entry output queue.
// Reset and stall:
//   Reset empties the pipeline and the queue and loads the register defaults.
//   When the receiver stalls, the queue fills and s_axis_tready drops; the
//   whole pipeline then holds, so no request is lost or repeated.
module lidar_scan_to_world_points (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Beam requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // beam_index[9:0], range_q[25:10], pose_x[49:26], pose_y[73:50],
  // heading[89:74], zero[95:90]
  input  logic [95:0] s_axis_tdata,
  // range_invalid[0]
  input  logic        s_axis_tuser,
  // World points
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // world_x[23:0], world_y[47:24], point_beam[57:48], zero[63:58]
  output logic [63:0] m_axis_tdata,
  // point_invalid[0]
  output logic        m_axis_tuser
);
  import lstw_pkg::*;

  lstw_cfg_t   cfg;
  logic        cfg_write;
  logic        en;
  lstw_side_t  in_side;
  logic        ang_valid;
  lstw_rot_t   ang_rot;
  logic        rot_valid;
  lstw_rot_t   rot_out;
  logic        pt_valid;
  lstw_point_t pt_out;
  lstw_point_t q_out;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_angle       <= 16'sd0;
      cfg.angle_step        <= 13'd143;
      cfg.window_half_width <= 15'd2458;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_START_ANGLE: cfg.start_angle       <= pwdata[15:0];
        REG_ANGLE_STEP:  cfg.angle_step        <= pwdata[12:0];
        REG_WINDOW:      cfg.window_half_width <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_START_ANGLE: prdata = {16'd0, cfg.start_angle};
      REG_ANGLE_STEP:  prdata = {19'd0, cfg.angle_step};
      REG_WINDOW:      prdata = {17'd0, cfg.window_half_width};
      default:         prdata = 32'd0;
    endcase
  end

  // Unpack the request
  assign in_side.beam   = s_axis_tdata[9:0];
  assign in_side.bad    = s_axis_tuser;
  assign in_side.pose_x = s_axis_tdata[49:26];
  assign in_side.pose_y = s_axis_tdata[73:50];

  // Advance the pipeline whenever the output queue has room
  assign s_axis_tready = en;

  lstw_angle u_angle (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_axis_tvalid),
    .in_side    (in_side),
    .in_range   (s_axis_tdata[25:10]),
    .in_heading (s_axis_tdata[89:74]),
    .cfg        (cfg),
    .out_valid  (ang_valid),
    .out_rot    (ang_rot)
  );

  lstw_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ang_valid),
    .in_rot    (ang_rot),
    .out_valid (rot_valid),
    .out_rot   (rot_out)
  );

  lstw_point u_point (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rot_valid),
    .in_rot    (rot_out),
    .out_valid (pt_valid),
    .out_point (pt_out)
  );

  lstw_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (pt_valid && en),
    .push_point (pt_out),
    .room       (en),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_point  (q_out)
  );

  // Pack the result
  assign m_axis_tdata = {6'd0, q_out.point_beam, q_out.world_y, q_out.world_x};
  assign m_axis_tuser = q_out.point_invalid;

  // The pipeline only holds while results wait in a full queue
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("pipeline stalled with an empty output queue");

  // A full queue that is not drained stays full
  a_stall_persists: assert property (@(posedge clk) disable iff (rst)
    (!s_axis_tready && !m_axis_tready) |=> !s_axis_tready)
    else $error("output queue freed without a pop");

  // A start angle write lands in the register
  a_cfg_start: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && paddr[3:2] == REG_START_ANGLE) |=>
      (cfg.start_angle == $signed($past(pwdata[15:0]))))
    else $error("start_angle write lost");

endmodule
